// ===== rtl/fdli_pkg.sv =====
// Shared types, constants and lookup tables for the face dof local index unit.
package fdli_pkg;

    localparam int MAX_EDGE_DOFS = 16;
    localparam int CNT_W         = $clog2(MAX_EDGE_DOFS + 1);
    localparam int IDX_W         = 2 * CNT_W;
    localparam int DOF_W         = 8;
    localparam int CELLS         = DOF_W;
    localparam int LATENCY       = CELLS + 1;
    localparam int CFG_W         = 5;

    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_ORIENT = 3'd1;
    localparam logic [2:0] ERR_FACE   = 3'd2;
    localparam logic [2:0] ERR_DIM    = 3'd3;
    localparam logic [2:0] ERR_RANGE  = 3'd4;

    localparam logic [1:0] DIM_NONE = 2'd0;
    localparam logic [1:0] DIM_1D   = 2'd1;
    localparam logic [1:0] DIM_2D   = 2'd2;

    // Selector codes: kf1, kf2, reversed kf1, reversed kf2.
    localparam logic [1:0] SEL_KF1  = 2'd0;
    localparam logic [1:0] SEL_KF2  = 2'd1;
    localparam logic [1:0] SEL_REV1 = 2'd2;
    localparam logic [1:0] SEL_REV2 = 2'd3;

    localparam logic [1:0] PICK_K1 [0:2][0:7] = '{
        '{SEL_KF1,  SEL_REV2, SEL_REV2, SEL_REV1, SEL_REV1, SEL_KF2,  SEL_KF2,  SEL_KF1},
        '{SEL_KF1,  SEL_KF2,  SEL_KF2,  SEL_REV1, SEL_REV1, SEL_REV2, SEL_REV2, SEL_KF1},
        '{SEL_REV1, SEL_KF2,  SEL_KF2,  SEL_KF1,  SEL_KF1,  SEL_REV2, SEL_REV2, SEL_REV1}
    };
    localparam logic [1:0] PICK_K2 [0:2][0:7] = '{
        '{SEL_REV2, SEL_KF1,  SEL_REV1, SEL_REV2, SEL_KF2,  SEL_REV1, SEL_KF1,  SEL_KF2},
        '{SEL_KF2,  SEL_KF1,  SEL_REV1, SEL_KF2,  SEL_REV2, SEL_REV1, SEL_KF1,  SEL_REV2},
        '{SEL_KF2,  SEL_REV1, SEL_KF1,  SEL_KF2,  SEL_REV2, SEL_KF1,  SEL_REV1, SEL_REV2}
    };
    localparam logic [1:0] FACE_GROUP [0:5] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1};

    typedef struct packed {
        logic [1:0]       dim;
        logic [2:0]       face;
        logic [3:0]       orient;
        logic [DOF_W-1:0] dof;
        logic [CNT_W-1:0] cnt;
        logic [DOF_W-1:0] work;
        logic [CNT_W-1:0] rem;
        logic [DOF_W-1:0] quo;
    } t_cell_data;

    function automatic logic [CNT_W-1:0] clamp_count(logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] c;
        begin
            if (v == '0) begin
                c = CNT_W'(1);
            end else if (int'(v) > MAX_EDGE_DOFS) begin
                c = CNT_W'(MAX_EDGE_DOFS);
            end else begin
                c = CNT_W'(v);
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/fdli_cell.sv =====
// One restoring division cell: produces one quotient bit per item and passes it on.
module fdli_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fdli_pkg::t_cell_data  i_data,
    output logic                  o_valid,
    output fdli_pkg::t_cell_data  o_data
);

    logic                          r_valid;
    fdli_pkg::t_cell_data          r_data;
    fdli_pkg::t_cell_data          n_data;
    logic [fdli_pkg::CNT_W:0]      rem_sh;
    logic                          take;

    always_comb begin
        rem_sh = {i_data.rem, i_data.work[fdli_pkg::DOF_W-1]};
        take   = (rem_sh >= {1'b0, i_data.cnt});
        n_data = i_data;
        n_data.work = {i_data.work[fdli_pkg::DOF_W-2:0], 1'b0};
        n_data.quo  = {i_data.quo[fdli_pkg::DOF_W-2:0], take};
        if (take) begin
            n_data.rem = fdli_pkg::CNT_W'(rem_sh - {1'b0, i_data.cnt});
        end else begin
            n_data.rem = rem_sh[fdli_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/fdli_map.sv =====
// Final stage: error checks, orientation table lookup and index assembly.
module fdli_map (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fdli_pkg::t_cell_data  i_data,
    output logic                  o_strobe,
    output logic [7:0]            o_local_index,
    output logic [2:0]            o_error_code
);

    logic                          r_strobe;
    logic [7:0]                    r_index;
    logic [2:0]                    r_err;
    logic [7:0]                    n_index;
    logic [2:0]                    n_err;
    logic [7:0]                    cnt8;
    logic [fdli_pkg::CNT_W-1:0]    kf1;
    logic [fdli_pkg::CNT_W-1:0]    kf2;
    logic [fdli_pkg::CNT_W-1:0]    k1;
    logic [fdli_pkg::CNT_W-1:0]    k2;
    logic [1:0]                    grp;
    logic [1:0]                    sel1;
    logic [1:0]                    sel2;
    logic [fdli_pkg::IDX_W-1:0]    idx3;

    function automatic logic [fdli_pkg::CNT_W-1:0] pick(
        logic [1:0] sel,
        logic [fdli_pkg::CNT_W-1:0] a,
        logic [fdli_pkg::CNT_W-1:0] b,
        logic [fdli_pkg::CNT_W-1:0] c
    );
        logic [fdli_pkg::CNT_W-1:0] r;
        begin
            case (sel)
                fdli_pkg::SEL_KF1:  r = a;
                fdli_pkg::SEL_KF2:  r = b;
                fdli_pkg::SEL_REV1: r = c - fdli_pkg::CNT_W'(1) - a;
                default:            r = c - fdli_pkg::CNT_W'(1) - b;
            endcase
            return r;
        end
    endfunction

    always_comb begin
        cnt8 = 8'(i_data.cnt);
        kf1  = i_data.rem;
        kf2  = i_data.quo[fdli_pkg::CNT_W-1:0];
        grp  = (i_data.face <= 3'd5) ? fdli_pkg::FACE_GROUP[i_data.face] : 2'd0;
        sel1 = fdli_pkg::PICK_K1[grp][i_data.orient[2:0]];
        sel2 = fdli_pkg::PICK_K2[grp][i_data.orient[2:0]];
        k1   = pick(sel1, kf1, kf2, i_data.cnt);
        k2   = pick(sel2, kf1, kf2, i_data.cnt);
        idx3 = fdli_pkg::IDX_W'(k1)
             + fdli_pkg::IDX_W'(fdli_pkg::IDX_W'(k2) * fdli_pkg::IDX_W'(i_data.cnt));

        n_err   = fdli_pkg::ERR_OK;
        n_index = 8'd0;
        case (i_data.dim)
            fdli_pkg::DIM_NONE: begin
                n_err = fdli_pkg::ERR_DIM;
            end
            fdli_pkg::DIM_1D: begin
                if (i_data.dof >= cnt8) begin
                    n_err = fdli_pkg::ERR_RANGE;
                end else begin
                    n_index = i_data.dof;
                end
            end
            fdli_pkg::DIM_2D: begin
                if (i_data.face > 3'd3) begin
                    n_err = fdli_pkg::ERR_FACE;
                end else if (i_data.dof >= cnt8) begin
                    n_err = fdli_pkg::ERR_RANGE;
                end else if (i_data.face <= 3'd1) begin
                    n_index = i_data.dof;
                end else begin
                    n_index = cnt8 - 8'd1 - i_data.dof;
                end
            end
            default: begin
                if (i_data.face > 3'd5) begin
                    n_err = fdli_pkg::ERR_FACE;
                end else if (i_data.orient > 4'd7) begin
                    n_err = fdli_pkg::ERR_ORIENT;
                end else if (i_data.quo >= cnt8) begin
                    // The quotient reaches count exactly when dof >= count * count.
                    n_err = fdli_pkg::ERR_RANGE;
                end else if (idx3 > fdli_pkg::IDX_W'(255)) begin
                    n_err = fdli_pkg::ERR_RANGE;
                end else begin
                    n_index = idx3[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index <= n_index;
        r_err   <= n_err;
    end

    assign o_strobe      = r_strobe;
    assign o_local_index = r_index;
    assign o_error_code  = r_err;

endmodule

// ===== rtl/face_dof_local_index_unit.sv =====
// Top level of the face dof local index unit: config register, divider cell chain, map stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------------
//  command  | start (in), busy (out)     | i_dimension, i_face_id, i_orientation, i_face_dof
//  result   | o_strobe (out)             | o_local_index, o_error_code
//  config   | i_cfg_valid, o_cfg_ready   | i_cfg_data (dofs_per_edge)
//
// One word is accepted every cycle; busy is never raised.
// Each word passes a chain of eight division cells, one quotient bit per cell, then the
// map stage: nine register stages in all, the last of which raises o_strobe with the result.
// Synchronous active-low reset clears the valid bits and sets dofs_per_edge to 2.
// Results are not flow controlled: the receiver must take each one in its strobe cycle.
module face_dof_local_index_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_dimension,
    input  logic [2:0]                  i_face_id,
    input  logic [3:0]                  i_orientation,
    input  logic [7:0]                  i_face_dof,
    output logic                        o_strobe,
    output logic [7:0]                  o_local_index,
    output logic [2:0]                  o_error_code,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fdli_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [fdli_pkg::CFG_W-1:0]  r_dofs_per_edge;
    logic                        chain_valid [0:fdli_pkg::CELLS];
    fdli_pkg::t_cell_data        chain_data  [0:fdli_pkg::CELLS];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dofs_per_edge <= fdli_pkg::CFG_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dofs_per_edge <= i_cfg_data;
        end
    end

    always_comb begin
        chain_valid[0]       = start && !busy;
        chain_data[0].dim    = i_dimension;
        chain_data[0].face   = i_face_id;
        chain_data[0].orient = i_orientation;
        chain_data[0].dof    = i_face_dof;
        chain_data[0].cnt    = fdli_pkg::clamp_count(r_dofs_per_edge);
        chain_data[0].work   = i_face_dof;
        chain_data[0].rem    = '0;
        chain_data[0].quo    = '0;
    end

    for (genvar g = 0; g < fdli_pkg::CELLS; g++) begin : g_cell
        fdli_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    fdli_map u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (chain_valid[fdli_pkg::CELLS]),
        .i_data        (chain_data[fdli_pkg::CELLS]),
        .o_strobe      (o_strobe),
        .o_local_index (o_local_index),
        .o_error_code  (o_error_code)
    );

    // Every accepted word yields exactly one result once it has passed the pipeline stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(fdli_pkg::LATENCY) o_strobe)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n, fdli_pkg::LATENCY))
            |-> $past(start && !busy, fdli_pkg::LATENCY))
        else $error("result strobe without an accepted word");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_error_code != fdli_pkg::ERR_OK) |-> (o_local_index == 8'd0))
        else $error("nonzero index reported with an error");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_error_code <= fdli_pkg::ERR_RANGE))
        else $error("undefined error code");

endmodule
